@@ hdl/chacha20_stream_encryptor_top_assert.svh @@
// assertion macros for the chacha20 stream encryptor
`ifndef CHACHA20_STREAM_ENCRYPTOR_TOP_ASSERT_SVH
`define CHACHA20_STREAM_ENCRYPTOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/cc20_pkg.sv @@
// shared types and constants for the chacha20 stream encryptor
package cc20_pkg;
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;
	localparam int unsigned NUM_ROUNDS = 20;

	typedef enum logic [2:0] {
		REG_KEY0 = 3'd0, REG_KEY1 = 3'd1, REG_KEY2 = 3'd2, REG_KEY3 = 3'd3,
		REG_NONCE_LO = 3'd4, REG_NONCE_HI = 3'd5, REG_INIT_CTR = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_ROUND, ST_FINAL, ST_OUT
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // load initial state from config and counter
		logic round;     // run one round (column or diagonal)
		logic finish;    // feed-forward add into keystream
		logic capture;   // take input byte and produce result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_block; // byte position is zero
	} dp_sts_t;
endpackage

@@ hdl/cc20_ctrl.sv @@
// controller state machine: sequences block generation and byte transactions
module cc20_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cc20_pkg::dp_sts_t sts,
	output cc20_pkg::dp_cmd_t cmd
);
	import cc20_pkg::*;
	`include "chacha20_stream_encryptor_top_assert.svh"

	ctl_state_t state_q, state_d;
	logic [4:0] round_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.need_block) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == 5'(NUM_ROUNDS - 1)) state_d = ST_FINAL;
			end
			ST_FINAL: state_d = ST_OUT;
			ST_OUT: begin
				if (in_valid && out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid && sts.need_block;
				if (!sts.need_block) begin
					in_ready = out_free;
					cmd.capture = in_valid && out_free;
				end
			end
			ST_ROUND: cmd.round = 1'b1;
			ST_FINAL: cmd.finish = 1'b1;
			ST_OUT: begin
				in_ready = out_free;
				cmd.capture = in_valid && out_free;
			end
			default: ;
		endcase
	end

	// state, round count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) round_q <= round_q + 5'd1;
			else round_q <= '0;
			if (cmd.capture) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`CC_ASSERT_IMP(a_ready_free, clk, arst_n, in_ready, out_free)
	`CC_ASSERT_NXT(a_capture_valid, clk, arst_n, cmd.capture, out_valid_q)
	`CC_ASSERT_IMP(a_round_range, clk, arst_n, state_q == ST_ROUND,
		round_q < 5'(NUM_ROUNDS))
endmodule

@@ hdl/cc20_dp.sv @@
// datapath: state words, quarter rounds, keystream and byte position
module cc20_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic [7:0]        plain_byte,
	input  logic              last_of_message,
	input  cc20_pkg::dp_cmd_t cmd,
	output cc20_pkg::dp_sts_t sts,
	output logic [7:0]        cipher_byte,
	output logic              cipher_last
);
	import cc20_pkg::*;

	logic [63:0] key_q [4];
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q, init_ctr_q, ctr_q;
	logic [5:0]  pos_q;
	logic        diag_q;
	logic [31:0] work_q [16];
	logic [31:0] init_w [16];
	logic [31:0] ks_q   [16];
	logic [31:0] nxt_w  [16];
	logic [7:0]  cipher_q;
	logic        last_q;
	logic [31:0] ks_word;
	logic [7:0]  ks_byte;

	function automatic logic [127:0] qr(input logic [31:0] a, b, c, d);
		logic [31:0] ta, tb, tc, td;
		ta = a + b; td = d ^ ta; td = {td[15:0], td[31:16]};
		tc = c + td; tb = b ^ tc; tb = {tb[19:0], tb[31:20]};
		ta = ta + tb; td = td ^ ta; td = {td[23:0], td[31:24]};
		tc = tc + td; tb = tb ^ tc; tb = {tb[24:0], tb[31:25]};
		return {ta, tb, tc, td};
	endfunction

	// initial block
	always_comb begin
		init_w[0] = SIGMA0; init_w[1] = SIGMA1;
		init_w[2] = SIGMA2; init_w[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = ctr_q;
		init_w[13] = nonce_lo_q[31:0];
		init_w[14] = nonce_lo_q[63:32];
		init_w[15] = nonce_hi_q;
	end

	// one column or diagonal round, four quarter rounds in parallel
	always_comb begin
		for (int i = 0; i < 16; i++) nxt_w[i] = work_q[i];
		for (int i = 0; i < 4; i++) begin
			logic [3:0] ia, ib, ic, id;
			ia = 4'(i);
			ib = diag_q ? 4'(4 + ((i + 1) % 4)) : 4'(4 + i);
			ic = diag_q ? 4'(8 + ((i + 2) % 4)) : 4'(8 + i);
			id = diag_q ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
			{nxt_w[ia], nxt_w[ib], nxt_w[ic], nxt_w[id]} =
				qr(work_q[ia], work_q[ib], work_q[ic], work_q[id]);
		end
	end

	assign ks_word = ks_q[pos_q[5:2]];
	assign ks_byte = 8'(ks_word >> {pos_q[1:0], 3'b000});
	assign sts.need_block = (pos_q == 6'd0);
	assign cipher_byte = cipher_q;
	assign cipher_last = last_q;

	// config registers, counter and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			init_ctr_q <= '0;
			ctr_q <= '0;
			pos_q <= '0;
			diag_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index <= 3'(REG_INIT_CTR)) begin
				pos_q <= '0;
				ctr_q <= init_ctr_q;
				unique case (cfg_index)
					3'(REG_NONCE_LO): nonce_lo_q <= cfg_data;
					3'(REG_NONCE_HI): nonce_hi_q <= cfg_data[31:0];
					3'(REG_INIT_CTR): begin
						init_ctr_q <= cfg_data[31:0];
						ctr_q <= cfg_data[31:0];
					end
					default: key_q[cfg_index[1:0]] <= cfg_data;
				endcase
			end
		end else begin
			if (cmd.load) diag_q <= 1'b0;
			else if (cmd.round) diag_q <= !diag_q;
			if (cmd.capture) begin
				if (last_of_message) begin
					pos_q <= '0;
					ctr_q <= init_ctr_q;
				end else begin
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) ctr_q <= ctr_q + 32'd1;
				end
			end
		end
	end

	// working words and keystream
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= init_w;
			ks_q <= init_w;
		end else if (cmd.round) begin
			work_q <= nxt_w;
		end else if (cmd.finish) begin
			for (int i = 0; i < 16; i++) ks_q[i] <= ks_q[i] + work_q[i];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cipher_q <= plain_byte ^ ks_byte;
			last_q <= last_of_message;
		end
	end
endmodule

@@ hdl/chacha20_stream_encryptor_top.sv @@
// top level of the chacha20 stream encryptor
// usage:
// - write key, nonce and initial counter through cfg_we / cfg_index / cfg_data
//   while idle; a write to index 0-6 restarts the message, reloads the counter
// - plaintext bytes enter on s_axis (tdata = plain_byte, tlast = end of message)
// - ciphertext bytes leave on m_axis (tdata = cipher_byte, tlast = end of message)
// - at the first byte of each 64-byte block the block function runs: a load,
//   20 rounds on four parallel quarter-round units, a feed-forward add,
//   then the byte is taken once the output register is free
// - other bytes are taken without running the block function when the output
//   register is free; output appears in the cycle after the byte is accepted
// - reset clears configuration to zero, counter and position to zero
// - when m_axis stalls the single output register holds the result and
//   s_axis_tready drops until it is taken
module chacha20_stream_encryptor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // plain_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // cipher_byte
	output logic        m_axis_tlast
);
	import cc20_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	cc20_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	cc20_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.plain_byte(s_axis_tdata), .last_of_message(s_axis_tlast),
		.cmd(cmd), .sts(sts),
		.cipher_byte(m_axis_tdata), .cipher_last(m_axis_tlast)
	);
endmodule
